@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the registry.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ src/hir_pkg.sv @@
// Package of the hold invoice registry: widths, codes, types and the SHA-256 constants.
`timescale 1ns / 1ps
package hir_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = 5;
    localparam logic [31:0] DEFAULT_EXPIRY = 32'd3600;
    localparam logic [16:0] PEER_NONE = 17'h10000;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_PAY = 3'd1;
    localparam logic [2:0] CMD_SETTLE = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;
    localparam logic [2:0] CMD_COUNT = 3'd5;

    localparam logic [1:0] PH_PENDING = 2'd0;
    localparam logic [1:0] PH_ACCEPTED = 2'd1;
    localparam logic [1:0] PH_SETTLED = 2'd2;
    localparam logic [1:0] PH_CANCELLED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // store the input beat's words and arguments
        logic scan_clr;   // restart the entry scan
        logic scan_step;  // examine the entry at the scan pointer
        logic hash_start; // start the digest of the latched preimage
        logic commit;     // apply the command's update and form the result
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic hash_done;
    } t_stat;

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction
endpackage

@@ src/hir_sha.sv @@
// One-block SHA-256 of a 256-bit message, one round per cycle.
`timescale 1ns / 1ps
module hir_sha (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_msg,
    output logic         o_done,
    output logic [255:0] o_digest
);
    localparam logic [255:0] H0 = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_done;
    logic [31:0] n_w, s0, s1, bs0, bs1, ch, mj, t1, t2;
    logic [255:0] n_dig;

    always_comb begin
        s0  = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1  = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
            ^ (r_w[14] >> 10);
        n_w = r_w[0] + s0 + r_w[9] + s1;
        bs1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
            ^ {r_v[4][24:0], r_v[4][31:25]};
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + bs1 + ch + hir_pkg::sha_k(r_rnd) + r_w[0];
        bs0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
            ^ {r_v[0][21:0], r_v[0][31:22]};
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = bs0 + mj;
        for (int j = 0; j < 8; j++) begin
            n_dig[255-32*j -: 32] = H0[255-32*j -: 32] + r_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
                for (int j = 0; j < 8; j++) begin
                    r_w[j] <= i_msg[255-32*j -: 32];
                    r_v[j] <= H0[255-32*j -: 32];
                end
                r_w[8] <= 32'h80000000;
                for (int j = 9; j < 15; j++) r_w[j] <= '0;
                r_w[15] <= 32'd256;
            end else if (r_busy) begin
                for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                r_w[15] <= n_w;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_digest = n_dig;
endmodule

@@ src/hir_datapath.sv @@
// Datapath of the registry: word buffer, entry table, scan logic and result forming.
`timescale 1ns / 1ps
module hir_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hir_pkg::t_cmd    i_cmd,
    output hir_pkg::t_stat   o_stat,
    input  logic [2:0]       i_command,
    input  logic [1:0]       i_word_index,
    input  logic [63:0]      i_key_word,
    input  logic [63:0]      i_preimage_word,
    input  logic [63:0]      i_amount,
    input  logic [31:0]      i_expiry_seconds,
    input  logic [63:0]      i_payment_id,
    input  logic [15:0]      i_peer_number,
    input  logic [1:0]       i_query_state,
    output logic             o_ok,
    output logic [4:0]       o_state_count
);
    localparam int E = hir_pkg::ENTRIES;
    localparam int IW = hir_pkg::IDX_W;

    // Hash words live in a memory, one 256-bit row per entry.
    logic [255:0] r_hash_mem [E];
    logic [255:0] r_hash_rd;
    logic [E-1:0] r_active;
    logic [1:0]   r_phase [E];
    logic [63:0]  r_inv_amt [E];
    logic [31:0]  r_expiry [E];
    logic [63:0]  r_paid_amt [E];
    logic [63:0]  r_paid_id [E];
    logic [16:0]  r_peer [E];

    logic [63:0]  r_key [4];
    logic [63:0]  r_pre [4];
    logic [2:0]   r_command;
    logic [63:0]  r_amount, r_payid;
    logic [31:0]  r_exp;
    logic [15:0]  r_peer_in;
    logic [1:0]   r_query;

    logic [IW:0]  r_ptr;      // entry being read
    logic [IW:0]  r_cmp_ptr;  // entry whose row is in r_hash_rd
    logic         r_cmp_vld;
    logic         r_found, r_free_found;
    logic [IW-1:0] r_hit, r_free;
    logic [4:0]   r_cnt;
    logic         r_ok;
    logic [4:0]   r_sc;
    logic         r_scan_done;

    logic [255:0] key_all, dig;
    logic         sha_done;
    logic [IW-1:0] cptr;

    assign key_all = {r_key[0], r_key[1], r_key[2], r_key[3]};
    assign cptr = r_cmp_ptr[IW-1:0];

    hir_sha u_sha (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.hash_start),
        .i_msg({r_pre[0], r_pre[1], r_pre[2], r_pre[3]}),
        .o_done(sha_done), .o_digest(dig)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_ptr < (IW+1)'(E)) begin
            r_hash_rd <= r_hash_mem[r_ptr[IW-1:0]];
        end
        if (i_cmd.commit && r_command == hir_pkg::CMD_ADD && r_free_found) begin
            r_hash_mem[r_free] <= key_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int j = 0; j < E; j++) begin
                r_phase[j] <= hir_pkg::PH_PENDING;
                r_paid_amt[j] <= '0;
                r_paid_id[j] <= '0;
                r_peer[j] <= hir_pkg::PEER_NONE;
            end
            for (int j = 0; j < 4; j++) begin
                r_key[j] <= '0;
                r_pre[j] <= '0;
            end
            r_ptr <= '0;
            r_cmp_vld <= 1'b0;
            r_scan_done <= 1'b0;
            r_found <= 1'b0;
            r_free_found <= 1'b0;
            r_cnt <= '0;
            r_ok <= 1'b0;
            r_sc <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_key[i_word_index] <= i_key_word;
                r_pre[i_word_index] <= i_preimage_word;
                r_command <= i_command;
                r_amount <= i_amount;
                r_exp <= i_expiry_seconds;
                r_payid <= i_payment_id;
                r_peer_in <= i_peer_number;
                r_query <= i_query_state;
            end
            if (i_cmd.scan_clr) begin
                r_ptr <= '0;
                r_cmp_vld <= 1'b0;
                r_scan_done <= 1'b0;
                r_found <= 1'b0;
                r_free_found <= 1'b0;
                r_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= r_ptr < (IW+1)'(E);
                r_cmp_ptr <= r_ptr;
                if (r_ptr < (IW+1)'(E)) r_ptr <= r_ptr + 1'b1;
                if (r_cmp_vld) begin
                    if (r_active[cptr] && r_hash_rd == key_all && !r_found) begin
                        r_found <= 1'b1;
                        r_hit <= cptr;
                    end
                    if (!r_active[cptr] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free <= cptr;
                    end
                    if (r_active[cptr] && r_phase[cptr] == r_query && r_cnt != 5'd31) begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                r_scan_done <= !r_cmp_vld && r_ptr == (IW+1)'(E);
            end
            if (i_cmd.commit) begin
                r_ok <= 1'b0;
                r_sc <= '0;
                case (r_command)
                    hir_pkg::CMD_ADD: begin
                        if (r_free_found) begin
                            r_active[r_free] <= 1'b1;
                            r_phase[r_free] <= hir_pkg::PH_PENDING;
                            r_paid_amt[r_free] <= '0;
                            r_paid_id[r_free] <= '0;
                            r_peer[r_free] <= hir_pkg::PEER_NONE;
                            r_inv_amt[r_free] <= r_amount;
                            r_expiry[r_free] <= (r_exp != '0) ? r_exp
                                                              : hir_pkg::DEFAULT_EXPIRY;
                            r_ok <= 1'b1;
                        end
                    end
                    hir_pkg::CMD_PAY: begin
                        if (r_found && r_phase[r_hit] == hir_pkg::PH_PENDING &&
                            !(r_inv_amt[r_hit] != '0 && r_amount < r_inv_amt[r_hit])) begin
                            r_paid_amt[r_hit] <= r_amount;
                            r_paid_id[r_hit] <= r_payid;
                            r_peer[r_hit] <= {1'b0, r_peer_in};
                            r_phase[r_hit] <= hir_pkg::PH_ACCEPTED;
                            r_ok <= 1'b1;
                        end
                    end
                    hir_pkg::CMD_SETTLE: begin
                        if (r_found && r_phase[r_hit] == hir_pkg::PH_ACCEPTED &&
                            dig == key_all) begin
                            r_phase[r_hit] <= hir_pkg::PH_SETTLED;
                            r_ok <= 1'b1;
                        end
                    end
                    hir_pkg::CMD_CANCEL: begin
                        if (r_found && !r_phase[r_hit][1]) begin
                            r_phase[r_hit] <= hir_pkg::PH_CANCELLED;
                            r_ok <= 1'b1;
                        end
                    end
                    hir_pkg::CMD_REMOVE: begin
                        if (r_found && r_phase[r_hit][1]) begin
                            r_active[r_hit] <= 1'b0;
                            r_phase[r_hit] <= hir_pkg::PH_PENDING;
                            r_paid_amt[r_hit] <= '0;
                            r_paid_id[r_hit] <= '0;
                            r_peer[r_hit] <= hir_pkg::PEER_NONE;
                            r_ok <= 1'b1;
                        end
                    end
                    hir_pkg::CMD_COUNT: begin
                        r_ok <= 1'b1;
                        r_sc <= r_cnt;
                    end
                    default: begin
                        r_ok <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_stat.scan_done = r_scan_done;
    assign o_stat.hash_done = sha_done;
    assign o_ok = r_ok;
    assign o_state_count = r_sc;
endmodule

@@ src/hir_ctrl.sv @@
// Controller of the registry: sequences latch, scan, digest, commit and result beat.
`timescale 1ns / 1ps
module hir_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_word_index,
    input  logic [2:0]     i_command,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hir_pkg::t_cmd  o_cmd,
    input  hir_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_HASH, S_COMMIT, S_OUT} t_state;
    t_state r_state;
    logic   r_settle;
    logic   r_out_valid;
    logic   acc;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '0;
        o_cmd.latch = acc;
        o_cmd.scan_clr = acc;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.hash_start = (r_state == S_SCAN) && i_stat.scan_done && r_settle;
        o_cmd.commit = (r_state == S_COMMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_settle <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
                    if (acc && i_word_index == 2'd3) begin
                        r_state <= S_SCAN;
                        r_settle <= (i_command == hir_pkg::CMD_SETTLE);
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_done) r_state <= r_settle ? S_HASH : S_COMMIT;
                end
                S_HASH: begin
                    if (i_stat.hash_done) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_state <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

@@ src/hold_invoice_registry.sv @@
// Top level of the hold invoice registry: controller, datapath and assertions.
`timescale 1ns / 1ps
// Input beats carry one 64-bit word of the payment hash and of the preimage each,
// selected by word_index. Beats with word index 0 to 2 only latch their words and
// give no result. A beat with word index 3 runs the command on the latched words.
// The command first scans all sixteen entries, reading one hash row of the table
// memory per cycle; settle then adds a SHA-256 digest of the preimage, one round
// per cycle. A full hash key thus costs four beats plus the run of the command.
// One command is worked on at a time: s_axis_tready is low while a command runs
// and while its result beat waits. The result beat carries ok and state_count
// and is held stable while m_axis_tready is low; a new input beat is taken only
// once it has gone. Reset (synchronous, active low) empties the table, returns
// every entry to pending with no payment, clears the word buffer and drops any
// pending result. Hash rows, invoice amounts and expiries need no reset since
// they are only read for active entries.
module hold_invoice_registry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fields from bit 0: command[2:0], word_index[4:3], key_word[68:5],
    // preimage_word[132:69], amount[196:133], expiry_seconds[228:197],
    // payment_id[292:229], peer_number[308:293], query_state[310:309]
    input  logic [311:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fields from bit 0: ok[0], state_count[5:1]
    output logic [7:0]   m_axis_tdata
);
`include "assert_macros.svh"

    hir_pkg::t_cmd  cmd;
    hir_pkg::t_stat stat;
    logic           ok;
    logic [4:0]     sc;

    hir_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_word_index(s_axis_tdata[4:3]),
        .i_command(s_axis_tdata[2:0]), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_stat(stat)
    );

    hir_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_command(s_axis_tdata[2:0]), .i_word_index(s_axis_tdata[4:3]),
        .i_key_word(s_axis_tdata[68:5]), .i_preimage_word(s_axis_tdata[132:69]),
        .i_amount(s_axis_tdata[196:133]), .i_expiry_seconds(s_axis_tdata[228:197]),
        .i_payment_id(s_axis_tdata[292:229]), .i_peer_number(s_axis_tdata[308:293]),
        .i_query_state(s_axis_tdata[310:309]),
        .o_ok(ok), .o_state_count(sc)
    );

    assign m_axis_tdata = {2'b00, sc, ok};

    // The input side is never open while a result beat waits.
    `ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid)
    // A commit always leads to a result beat in the next cycle.
    `ASSERT_CLK(a_commit_out, i_clk, i_rst_n, cmd.commit |=> m_axis_tvalid)
    // Only a count returns a non-zero count.
    `ASSERT_CLK(a_cnt_ok, i_clk, i_rst_n, (m_axis_tvalid && sc != 5'd0) |-> ok)
endmodule
